// File: hdl/tewm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tewm_pkg;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 20;
	localparam int CNT_W    = 8;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam int DIV_STEPS = 20;

	// register indexes
	localparam logic [2:0] REG_UPPER   = 3'd0;
	localparam logic [2:0] REG_LOWER   = 3'd1;
	localparam logic [2:0] REG_PERIOD  = 3'd2;
	localparam logic [2:0] REG_TLIMIT  = 3'd3;
	localparam logic [2:0] REG_CLIMIT  = 3'd4;
	localparam logic [2:0] REG_EVRES   = 3'd5;
	localparam logic [2:0] REG_NORMRES = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIVIDE,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic load;      // capture input item
		logic read;      // read sensor memory
		logic eval;      // update state, start divide
		logic div_step;  // one divide iteration
		logic div_done;  // quotient finished
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} status_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] upper;
		logic signed [SAMPLE_W-1:0] lower;
		logic [31:0] period;
		logic [31:0] tlimit;
		logic [CNT_W-1:0] climit;
		logic [1:0] evres;
		logic [1:0] normres;
	} cfg_t;
endpackage
`default_nettype wire

// File: hdl/tewm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tewm_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_fire,
	input  wire tewm_pkg::status_t status,
	output tewm_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	import tewm_pkg::*;
	state_t state_q, state_nx;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_nx = ST_READ;
			ST_READ:   state_nx = ST_EVAL;
			ST_EVAL:   state_nx = status.need_div ? ST_DIVIDE : ST_OUTPUT;
			ST_DIVIDE: if (status.div_last) state_nx = ST_OUTPUT;
			ST_OUTPUT: if (out_fire) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
			end
			ST_READ: cmd.read = 1'b1;
			ST_EVAL: cmd.eval = 1'b1;
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				cmd.div_done = status.div_last;
			end
			ST_OUTPUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: hdl/tewm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tewm_dp #(
	parameter int SENSOR_COUNT = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tewm_pkg::cmd_t cmd,
	input  wire tewm_pkg::cfg_t cfg,
	input  wire logic [31:0] now_time,
	input  wire logic signed [11:0] temp_sample,
	input  wire logic read_ok,
	input  wire logic res_write_ok,
	output tewm_pkg::status_t status,
	output logic [76:0] result
);
	import tewm_pkg::*;
	localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SENSOR_COUNT - 1);

	// per-sensor state in flip-flops, read at the slot index
	logic [31:0] last_q [SENSOR_COUNT];
	logic [31:0] start_q [SENSOR_COUNT];
	logic [CNT_W-1:0] cnt_q [SENSOR_COUNT];
	logic [SENSOR_COUNT-1:0] flag_q;
	logic signed [SAMPLE_W-1:0] min_q [SENSOR_COUNT];
	logic signed [SAMPLE_W-1:0] max_q [SENSOR_COUNT];
	logic [SUM_W-1:0] sum_q [SENSOR_COUNT];

	logic [IDX_W-1:0] slot_q;
	logic [31:0] now_q;
	logic signed [SAMPLE_W-1:0] t_q;
	logic rd_q, wr_q;

	// values read in the read state
	logic [31:0] r_last_q, r_start_q;
	logic [CNT_W-1:0] r_cnt_q;
	logic r_flag_q;
	logic signed [SAMPLE_W-1:0] r_min_q, r_max_q;
	logic [SUM_W-1:0] r_sum_q;

	// result fields
	logic used_q, rqv_q, done_q, act_q;
	logic [1:0] rqc_q;
	logic signed [SAMPLE_W-1:0] omin_q, omax_q;
	logic [SAMPLE_W-1:0] oavg_q;
	logic [31:0] oend_q;

	// divider
	logic [SUM_W-1:0] rem_mag_q, quo_q;
	logic [SUM_W:0] part_q;
	logic [CNT_W-1:0] div_q;
	logic neg_q;
	logic [4:0] step_q;

	// evaluation
	logic due, out_range, start_ok, close_cond, close_ok, ok;
	logic [CNT_W-1:0] cnt_inc, cnt_new;
	logic signed [SAMPLE_W-1:0] min_new, max_new, mn1, mx1;
	logic [SUM_W-1:0] sum_base, sum_new;
	logic flag_mid, stop_start;

	always_comb begin
		due = ((now_q - r_last_q) > cfg.period) && rd_q;
		cnt_inc = (r_cnt_q < COUNT_MAX) ? r_cnt_q + 1'b1 : r_cnt_q;
		out_range = (t_q > cfg.upper) || (t_q < cfg.lower);
		stop_start = out_range && !wr_q;
		start_ok = out_range && wr_q;
		flag_mid = start_ok ? 1'b1 : r_flag_q;
		cnt_new = start_ok ? CNT_W'(1) : cnt_inc;
		mn1 = start_ok ? t_q : r_min_q;
		mx1 = start_ok ? t_q : r_max_q;
		sum_base = start_ok ? '0 : r_sum_q;
		sum_new = sum_base + SUM_W'(t_q);
		min_new = (t_q < mn1) ? t_q : mn1;
		max_new = (t_q > mx1) ? t_q : mx1;
		close_cond = !stop_start && flag_mid &&
			(((now_q - (start_ok ? now_q : r_start_q)) > cfg.tlimit) ||
			(cnt_new > cfg.climit));
		close_ok = close_cond && wr_q;
		ok = !stop_start && !(close_cond && !wr_q);
	end

	assign status = '{
		need_div: cmd.eval && due && close_ok && (cnt_new != '0),
		div_last: (step_q == 5'(DIV_STEPS - 1))
	};

	// capture item, advance slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= LAST_SLOT;
		end else if (cmd.load) begin
			slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_time;
			t_q <= temp_sample;
			rd_q <= read_ok;
			wr_q <= res_write_ok;
		end
		if (cmd.read) begin
			r_last_q <= last_q[slot_q];
			r_start_q <= start_q[slot_q];
			r_cnt_q <= cnt_q[slot_q];
			r_flag_q <= flag_q[slot_q];
			r_min_q <= min_q[slot_q];
			r_max_q <= max_q[slot_q];
			r_sum_q <= sum_q[slot_q];
		end
	end

	// write back sensor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
			for (int k = 0; k < SENSOR_COUNT; k++) begin
				last_q[k] <= '0;
				start_q[k] <= '0;
				cnt_q[k] <= '0;
				min_q[k] <= '0;
				max_q[k] <= '0;
				sum_q[k] <= '0;
			end
		end else if (cmd.eval && due) begin
			cnt_q[slot_q] <= cnt_new;
			if (start_ok) start_q[slot_q] <= now_q;
			if (!stop_start) begin
				flag_q[slot_q] <= flag_mid && !close_ok;
				if (flag_mid) begin
					min_q[slot_q] <= min_new;
					max_q[slot_q] <= max_new;
					sum_q[slot_q] <= sum_new;
				end else if (start_ok) begin
					sum_q[slot_q] <= '0;
				end
			end
			if (ok) last_q[slot_q] <= now_q;
		end
	end

	// result fields and divider, one quotient bit a step
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			used_q <= due && ok;
			rqv_q <= due && (out_range || close_cond);
			rqc_q <= !due ? 2'd0 : close_cond ? cfg.normres :
				out_range ? cfg.evres : 2'd0;
			// a refused start leaves the flag as it was
			act_q <= (due && !stop_start) ? (flag_mid && !close_ok) : r_flag_q;
			done_q <= due && close_ok;
			omin_q <= (due && close_ok) ? min_new : '0;
			omax_q <= (due && close_ok) ? max_new : '0;
			oend_q <= (due && close_ok) ? now_q : '0;
			oavg_q <= '0;
			neg_q <= sum_new[SUM_W-1];
			rem_mag_q <= sum_new[SUM_W-1] ? SUM_W'(-sum_new) : sum_new;
			quo_q <= '0;
			part_q <= '0;
			div_q <= cnt_new;
			step_q <= '0;
		end else if (cmd.div_step) begin
			logic [SUM_W:0] trial;
			logic [SUM_W-1:0] q;
			logic [SUM_W-1:0] qs;
			logic signed [SUM_W:0] sq;
			trial = {part_q[SUM_W-1:0], rem_mag_q[SUM_W-1]};
			q = {quo_q[SUM_W-2:0], 1'b0};
			if (trial >= {{(SUM_W+1-CNT_W){1'b0}}, div_q}) begin
				trial = trial - {{(SUM_W+1-CNT_W){1'b0}}, div_q};
				q[0] = 1'b1;
			end
			part_q <= trial;
			quo_q <= q;
			rem_mag_q <= {rem_mag_q[SUM_W-2:0], 1'b0};
			step_q <= step_q + 1'b1;
			qs = neg_q ? SUM_W'(-q) : q;
			sq = $signed({qs[SUM_W-1], qs});
			if (cmd.div_done) begin
				if (sq > 21'sd2047) oavg_q <= 12'h7FF;
				else if (sq < -21'sd2048) oavg_q <= 12'h800;
				else oavg_q <= qs[SAMPLE_W-1:0];
			end
		end
	end

	// sensor_slot, sample_used, res_request_valid/code, event_active,
	// event_done, event_min, event_max, event_average, event_end_time
	assign result = {oend_q, oavg_q, omax_q, omin_q, done_q, act_q,
		rqc_q, rqv_q, used_q, 3'(slot_q)};
endmodule
`default_nettype wire

// File: hdl/tewm_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module tewm_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output tewm_pkg::cfg_t cfg
);
	import tewm_pkg::*;
	logic [2:0] idx;
	assign idx = paddr[4:2];

	// write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.upper <= 12'sd2047;
			cfg.lower <= -12'sd2048;
			cfg.period <= '0;
			cfg.tlimit <= 32'd1000;
			cfg.climit <= 8'd16;
			cfg.evres <= 2'd3;
			cfg.normres <= 2'd0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_UPPER:   cfg.upper <= pwdata[11:0];
				REG_LOWER:   cfg.lower <= pwdata[11:0];
				REG_PERIOD:  cfg.period <= pwdata;
				REG_TLIMIT:  cfg.tlimit <= pwdata;
				REG_CLIMIT:  cfg.climit <= pwdata[7:0];
				REG_EVRES:   cfg.evres <= pwdata[1:0];
				REG_NORMRES: cfg.normres <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// read decode
	always_comb begin
		unique case (idx)
			REG_UPPER:   prdata = {{20{cfg.upper[11]}}, cfg.upper};
			REG_LOWER:   prdata = {{20{cfg.lower[11]}}, cfg.lower};
			REG_PERIOD:  prdata = cfg.period;
			REG_TLIMIT:  prdata = cfg.tlimit;
			REG_CLIMIT:  prdata = {24'd0, cfg.climit};
			REG_EVRES:   prdata = {30'd0, cfg.evres};
			REG_NORMRES: prdata = {30'd0, cfg.normres};
			default:     prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: hdl/temp_event_window_monitor.sv
// Temperature event window monitor.
// Slave stream: one poll slot per transfer; s_tdata carries now_time,
// temp_sample, read_ok and res_write_ok. Master stream: one result per slot
// with the slot index, flags, resolution request and the closed event record.
// APB port: seven shared registers at byte addresses 0..24, pready tied high.
// m_tvalid rises after the read and evaluate states when no event closes; when
// an event closes, the one-bit-a-step divider for the average runs before it
// rises. One item is in flight at a time, so a new item is taken only after
// the previous result has gone out on the master stream.
// s_tready is high only while the block is idle. When the receiver stalls,
// the result holds on m_tdata and no new item is taken.
// Reset clears all per-sensor state, loads register reset values and sets
// the slot counter so that the first slot handled is sensor 0.
`timescale 1ns / 1ps
`default_nettype none
module temp_event_window_monitor #(
	parameter int SENSOR_COUNT = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// [31:0] now_time, [43:32] temp_sample, [44] read_ok, [45] res_write_ok
	input  wire logic [47:0] s_tdata,
	output logic m_tvalid,
	input  wire logic m_tready,
	// [2:0] sensor_slot, [3] sample_used, [4] res_request_valid,
	// [6:5] res_request_code, [7] event_active, [8] event_done,
	// [20:9] event_min, [32:21] event_max, [44:33] event_average,
	// [76:45] event_end_time
	output logic [79:0] m_tdata,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tewm_pkg::*;
	cfg_t cfg;
	cmd_t cmd;
	status_t status;
	logic busy;
	logic [76:0] res_lo;

	assign pready = 1'b1;
	assign s_tready = !busy;

	tewm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	tewm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready),
		.status, .cmd, .busy, .out_valid(m_tvalid)
	);

	tewm_dp #(.SENSOR_COUNT(SENSOR_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .cfg,
		.now_time(s_tdata[31:0]),
		.temp_sample(s_tdata[43:32]),
		.read_ok(s_tdata[44]),
		.res_write_ok(s_tdata[45]),
		.status, .result(res_lo)
	);

	assign m_tdata = {3'd0, res_lo};
endmodule
`default_nettype wire

// File: hdl/tewm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tewm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [79:0] m_tdata
);
	// no new item while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during output");
	// no result is valid during the read step that follows an input transfer
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
	// a closed event always means a resolution request and no active flag
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> (m_tdata[4] && !m_tdata[7]))
		else $error("bad close record");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");
endmodule

bind temp_event_window_monitor tewm_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

// File: tb/temp_event_window_monitor_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module temp_event_window_monitor_tb;
	import tewm_pkg::*;

	localparam int NSENS = 8;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic res_write_ok;
		logic read_ok;
		logic signed [11:0] temp_sample;
		logic [31:0] now_time;
	} slot_in_t;

	typedef struct packed {
		logic [31:0] event_end_time;
		logic signed [11:0] event_average;
		logic signed [11:0] event_max;
		logic signed [11:0] event_min;
		logic event_done;
		logic event_active;
		logic [1:0] res_request_code;
		logic res_request_valid;
		logic sample_used;
		logic [2:0] sensor_slot;
	} slot_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	temp_event_window_monitor #(.SENSOR_COUNT(NSENS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// shadow of the block's registers and per-sensor state
	logic signed [11:0] sh_upper, sh_lower;
	logic [31:0] sh_period, sh_tlimit;
	logic [7:0] sh_climit;
	logic [1:0] sh_evres, sh_normres;
	logic [2:0] sh_slot;
	logic [31:0] sh_last[NSENS];
	logic [31:0] sh_start[NSENS];
	logic [7:0] sh_count[NSENS];
	logic sh_flag[NSENS];
	logic signed [11:0] sh_min[NSENS], sh_max[NSENS];
	logic [19:0] sh_sum[NSENS];

	slot_in_t pending_slots[$];
	slot_out_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	int closes_seen = 0;
	int idle_cycles = 0;
	logic no_idle = 1'b0;
	logic hold_off = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	function automatic slot_out_t monitor_step(input slot_in_t it);
		slot_out_t r;
		int i;
		logic ok;
		logic signed [19:0] s;
		longint a;
		r = '0;
		sh_slot = (sh_slot == NSENS - 1) ? 3'd0 : sh_slot + 3'd1;
		i = sh_slot;
		if ((it.now_time - sh_last[i]) > sh_period && it.read_ok) begin
			ok = 1'b1;
			if (sh_count[i] < 8'hFF)
				sh_count[i]++;
			if (it.temp_sample > sh_upper || it.temp_sample < sh_lower) begin
				r.res_request_valid = 1'b1;
				r.res_request_code = sh_evres;
				if (!it.res_write_ok) begin
					ok = 1'b0;
				end else begin
					sh_flag[i] = 1'b1;
					sh_count[i] = 8'd1;
					sh_min[i] = it.temp_sample;
					sh_max[i] = it.temp_sample;
					sh_sum[i] = '0;
					sh_start[i] = it.now_time;
				end
			end
			if (ok && sh_flag[i]) begin
				sh_sum[i] = sh_sum[i] + {{8{it.temp_sample[11]}}, it.temp_sample};
				if (it.temp_sample > sh_max[i])
					sh_max[i] = it.temp_sample;
				if (it.temp_sample < sh_min[i])
					sh_min[i] = it.temp_sample;
				if ((it.now_time - sh_start[i]) > sh_tlimit || sh_count[i] > sh_climit) begin
					r.res_request_valid = 1'b1;
					r.res_request_code = sh_normres;
					if (!it.res_write_ok) begin
						ok = 1'b0;
					end else begin
						s = sh_sum[i];
						a = 0;
						if (sh_count[i] != 0)
							a = longint'(s) / longint'(sh_count[i]);
						if (a > 2047) a = 2047;
						if (a < -2048) a = -2048;
						sh_flag[i] = 1'b0;
						r.event_done = 1'b1;
						r.event_min = sh_min[i];
						r.event_max = sh_max[i];
						r.event_average = a[11:0];
						r.event_end_time = it.now_time;
					end
				end
			end
			if (ok) begin
				sh_last[i] = it.now_time;
				r.sample_used = 1'b1;
			end
		end
		r.sensor_slot = i[2:0];
		r.event_active = sh_flag[i];
		return r;
	endfunction

	// drive the slave stream from the queue of pending slots
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_results.push_back(monitor_step(slot_in_t'(s_tdata[45:0])));
			void'(pending_slots.pop_front());
		end
		if (pending_slots.size() != 0 &&
				((s_tvalid && !s_tready) || no_idle || $urandom_range(99) >= 29)) begin
			if (!(s_tvalid && !s_tready))
				s_tdata <= {2'b00, pending_slots[0]};
			s_tvalid <= 1'b1;
		end else if (!(s_tvalid && !s_tready)) begin
			s_tvalid <= 1'b0;
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		slot_out_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[76:0];
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_results.pop_front();
				if (want.event_done) closes_seen++;
				if (got.sensor_slot != want.sensor_slot)
					report_mismatch("sensor_slot", got.sensor_slot, want.sensor_slot);
				if (got.sample_used != want.sample_used)
					report_mismatch("sample_used", got.sample_used, want.sample_used);
				if (got.res_request_valid != want.res_request_valid)
					report_mismatch("res_request_valid", got.res_request_valid,
						want.res_request_valid);
				if (got.res_request_code != want.res_request_code)
					report_mismatch("res_request_code", got.res_request_code,
						want.res_request_code);
				if (got.event_active != want.event_active)
					report_mismatch("event_active", got.event_active, want.event_active);
				if (got.event_done != want.event_done)
					report_mismatch("event_done", got.event_done, want.event_done);
				if (got.event_min != want.event_min)
					report_mismatch("event_min", got.event_min, want.event_min);
				if (got.event_max != want.event_max)
					report_mismatch("event_max", got.event_max, want.event_max);
				if (got.event_average != want.event_average)
					report_mismatch("event_average", got.event_average, want.event_average);
				if (got.event_end_time != want.event_end_time)
					report_mismatch("event_end_time", got.event_end_time,
						want.event_end_time);
			end
		end
		m_tready <= !hold_off && (no_idle || $urandom_range(99) >= 29);
	end

	// watchdog: count cycles with no transfer on either stream and no APB select
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("temp_event_window_monitor_tb: FAIL");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_UPPER:   sh_upper = val[11:0];
			REG_LOWER:   sh_lower = val[11:0];
			REG_PERIOD:  sh_period = val;
			REG_TLIMIT:  sh_tlimit = val;
			REG_CLIMIT:  sh_climit = val[7:0];
			REG_EVRES:   sh_evres = val[1:0];
			REG_NORMRES: sh_normres = val[1:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input int up, input int lo, input logic [31:0] per,
			input logic [31:0] tl, input int cl, input int er, input int nr);
		reg_write(REG_UPPER, up);
		reg_write(REG_LOWER, lo);
		reg_write(REG_PERIOD, per);
		reg_write(REG_TLIMIT, tl);
		reg_write(REG_CLIMIT, cl);
		reg_write(REG_EVRES, er);
		reg_write(REG_NORMRES, nr);
	endtask

	// wait for the block to drain before touching registers
	task automatic drain();
		while (pending_slots.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic slot_in_t make_slot(input logic [31:0] t, input int smp,
			input logic rok, input logic wok);
		slot_in_t s;
		s.now_time = t;
		s.temp_sample = smp;
		s.read_ok = rok;
		s.res_write_ok = wok;
		return s;
	endfunction

	// random phase: mostly good reads around thresholds with event bursts
	task automatic random_phase(input int n, inout logic [31:0] tick);
		int k, smp;
		logic rok, wok;
		for (k = 0; k < n; k++) begin
			tick += $urandom_range(40);
			if ($urandom_range(99) < 3) tick = $urandom;
			case ($urandom_range(9))
				0: smp = $urandom_range(4095) - 2048;
				1, 2: smp = int'(sh_upper) + 1 + $urandom_range(30);
				3: smp = int'(sh_lower) - 1 - $urandom_range(30);
				default: smp = int'(sh_lower) + $urandom_range(
					(int'(sh_upper) > int'(sh_lower)) ? int'(sh_upper) - int'(sh_lower) : 0);
			endcase
			if (smp > 2047) smp = 2047;
			if (smp < -2048) smp = -2048;
			rok = $urandom_range(99) < 92;
			wok = $urandom_range(99) < 90;
			pending_slots.push_back(make_slot(tick, smp, rok, wok));
		end
	endtask

	initial begin
		logic [31:0] tick;
		int k;
		sh_upper = 12'sd2047; sh_lower = -12'sd2048; sh_period = 0;
		sh_tlimit = 1000; sh_climit = 16; sh_evres = 3; sh_normres = 0;
		sh_slot = NSENS - 1;
		for (k = 0; k < NSENS; k++) begin
			sh_last[k] = 0; sh_start[k] = 0; sh_count[k] = 0; sh_flag[k] = 0;
			sh_min[k] = 0; sh_max[k] = 0; sh_sum[k] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: tight thresholds, small limits
		set_all(100, -100, 0, 50, 2, 2, 1);
		tick = 10;
		pending_slots.push_back(make_slot(0, 0, 1, 1));          // not due
		pending_slots.push_back(make_slot(5, 2047, 0, 1));       // read error
		pending_slots.push_back(make_slot(5, 2047, 1, 0));       // refused at start
		pending_slots.push_back(make_slot(5, -2048, 1, 1));      // start low
		for (k = 0; k < 4; k++) pending_slots.push_back(make_slot(6, 500, 1, 1));
		for (k = 0; k < 16; k++)
			pending_slots.push_back(make_slot(20 + k, (k % 2) ? 2047 : -2048, 1, k != 9));
		drain();

		// inverted thresholds: every sample restarts an event
		set_all(-2048, 2047, 0, 32'hFFFF_FFFF, 255, 1, 3);
		for (k = 0; k < 8 * 10; k++)
			pending_slots.push_back(make_slot(100 + k, 2047, 1, 1));
		drain();

		// zero count limit: start and close in one slot
		set_all(0, 0, 0, 0, 0, 3, 2);
		for (k = 0; k < 24; k++)
			pending_slots.push_back(make_slot(1000 + k, (k % 3) - 1, 1, 1));
		drain();

		// random phases over several settings
		set_all(300, -300, 3, 200, 6, 2, 0);
		tick = 5000;
		random_phase(150, tick);
		// long receiver hold-off while the sender keeps offering
		no_idle = 1'b1;
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
		repeat (200) @(posedge clk);
		no_idle = 1'b0;
		drain();
		set_all($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
			$urandom_range(20), $urandom_range(400), $urandom_range(30),
			$urandom_range(3), $urandom_range(3));
		random_phase(130, tick);
		drain();
		set_all(1000, -1000, 32'hFFFF_FFFF, 30, 4, 0, 3);
		random_phase(20, tick);
		drain();
		set_all(50, -50, 0, 100, 10, 1, 2);
		random_phase(130, tick);
		drain();
		repeat (40) @(posedge clk);

		$display("covered %0d results, %0d closed events, over seven register settings",
			results_seen, closes_seen);
		if (errors == 0)
			$display("temp_event_window_monitor_tb: PASS");
		else
			$display("temp_event_window_monitor_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
